// ===== hdl/heap_sort_engine_defines.svh =====
// ----------------------------------------------------------------------------
// heap_sort_engine_defines
// assertion macros used by the heap sort engine controller
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_DEFINES_SVH
`define HEAP_SORT_ENGINE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define HSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// shared types and constants of the heap sort engine
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 32;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BUILD_NEXT,
    ST_SIFT_LOAD,
    ST_SIFT_CHK,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_EXT_NEXT,
    ST_EXT_RDI,
    ST_EXT_SWAP,
    ST_EMIT
  } hse_state_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SETUP,
    DP_BUILD_RD,
    DP_HOLD,
    DP_SIFT_CHK,
    DP_SIFT_L,
    DP_SIFT_R,
    DP_EXT_INIT,
    DP_EXT_RD0,
    DP_EXT_RDI,
    DP_EXT_SWAP,
    DP_EMIT_INIT,
    DP_EMIT
  } hse_op_t;

  typedef struct packed {
    hse_op_t op;
  } hse_cmd_t;

  typedef struct packed {
    logic left_in;    // left child lies inside the heap
    logic right_in;   // right child lies inside the heap
    logic descend_l;  // held value smaller than left child
    logic descend_r;  // held value smaller than larger child
    logic i_zero;     // loop index at zero
    logic n_lt2;      // fewer than two values held
    logic emit_last;  // word on the output is the final one
  } hse_status_t;

endpackage

// ===== hdl/hse_ctrl.sv =====
// ----------------------------------------------------------------------------
// hse_ctrl
// sequencer for load, heap build, extraction and emission
// ----------------------------------------------------------------------------
`include "heap_sort_engine_defines.svh"

module hse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last,
  input  hse_pkg::hse_status_t status,
  output hse_pkg::hse_cmd_t   cmd,
  output logic                busy,
  output logic                out_strobe
);

  hse_pkg::hse_state_t state_r, state_nxt, done_state;
  logic                extract_r, extract_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hse_pkg::ST_IDLE;
      extract_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      extract_r <= extract_nxt;
    end
  end

  assign done_state = extract_r ? hse_pkg::ST_EXT_NEXT : hse_pkg::ST_BUILD_NEXT;

  always_comb begin
    state_nxt   = state_r;
    extract_nxt = extract_r;
    cmd.op      = hse_pkg::DP_NOP;
    unique case (state_r)
      hse_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op = hse_pkg::DP_LOAD;
          if (in_last) state_nxt = hse_pkg::ST_SETUP;
        end
      end
      hse_pkg::ST_SETUP: begin
        if (status.n_lt2) begin
          cmd.op    = hse_pkg::DP_EMIT_INIT;
          state_nxt = hse_pkg::ST_EMIT;
        end else begin
          cmd.op      = hse_pkg::DP_SETUP;
          extract_nxt = 1'b0;
          state_nxt   = hse_pkg::ST_BUILD_NEXT;
        end
      end
      hse_pkg::ST_BUILD_NEXT: begin
        if (status.i_zero) begin
          cmd.op      = hse_pkg::DP_EXT_INIT;
          extract_nxt = 1'b1;
          state_nxt   = hse_pkg::ST_EXT_NEXT;
        end else begin
          cmd.op    = hse_pkg::DP_BUILD_RD;
          state_nxt = hse_pkg::ST_SIFT_LOAD;
        end
      end
      hse_pkg::ST_SIFT_LOAD: begin
        cmd.op    = hse_pkg::DP_HOLD;
        state_nxt = hse_pkg::ST_SIFT_CHK;
      end
      hse_pkg::ST_SIFT_CHK: begin
        cmd.op    = hse_pkg::DP_SIFT_CHK;
        state_nxt = status.left_in ? hse_pkg::ST_SIFT_L : done_state;
      end
      hse_pkg::ST_SIFT_L: begin
        cmd.op = hse_pkg::DP_SIFT_L;
        if (status.right_in)       state_nxt = hse_pkg::ST_SIFT_R;
        else if (status.descend_l) state_nxt = hse_pkg::ST_SIFT_CHK;
        else                       state_nxt = done_state;
      end
      hse_pkg::ST_SIFT_R: begin
        cmd.op    = hse_pkg::DP_SIFT_R;
        state_nxt = status.descend_r ? hse_pkg::ST_SIFT_CHK : done_state;
      end
      hse_pkg::ST_EXT_NEXT: begin
        if (status.i_zero) begin
          cmd.op    = hse_pkg::DP_EMIT_INIT;
          state_nxt = hse_pkg::ST_EMIT;
        end else begin
          cmd.op    = hse_pkg::DP_EXT_RD0;
          state_nxt = hse_pkg::ST_EXT_RDI;
        end
      end
      hse_pkg::ST_EXT_RDI: begin
        cmd.op    = hse_pkg::DP_EXT_RDI;
        state_nxt = hse_pkg::ST_EXT_SWAP;
      end
      hse_pkg::ST_EXT_SWAP: begin
        cmd.op    = hse_pkg::DP_EXT_SWAP;
        state_nxt = hse_pkg::ST_SIFT_CHK;
      end
      hse_pkg::ST_EMIT: begin
        cmd.op = hse_pkg::DP_EMIT;
        if (status.emit_last) state_nxt = hse_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hse_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != hse_pkg::ST_IDLE);
  assign out_strobe = (state_r == hse_pkg::ST_EMIT);

  `HSE_ASSERT_NXT(a_last_starts_sort, clk, rst_n, start && !busy && in_last, busy,
    "last word did not start the sort")
  `HSE_ASSERT_NXT(a_plain_load_idle, clk, rst_n, start && !busy && !in_last, !busy,
    "plain load left the engine busy")
  `HSE_ASSERT_NXT(a_final_ends_run, clk, rst_n, out_strobe && status.emit_last, !busy,
    "engine still busy after final word")
  `HSE_ASSERT_NXT(a_emit_contiguous, clk, rst_n, out_strobe && !status.emit_last, out_strobe,
    "gap in the result burst")

endmodule

// ===== hdl/hse_datapath.sv =====
// ----------------------------------------------------------------------------
// hse_datapath
// element store, index registers and compare logic of the heap sort
// ----------------------------------------------------------------------------
module hse_datapath #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hse_pkg::hse_cmd_t                 cmd,
  input  logic signed [hse_pkg::DATA_W-1:0] in_value,
  output hse_pkg::hse_status_t              status,
  output logic signed [hse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_final_res,
  output logic                              out_dropped
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int LW = AW + 2;

  logic signed [hse_pkg::DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [hse_pkg::DATA_W-1:0] rd_data_r;
  logic signed [hse_pkg::DATA_W-1:0] hold_r;
  logic signed [hse_pkg::DATA_W-1:0] big_val_r;
  logic        [AW-1:0]              big_idx_r;
  logic        [AW-1:0]              node_r;
  logic        [AW-1:0]              end_r;
  logic        [CW-1:0]              i_r;
  logic        [CW-1:0]              count_r;
  logic                              ovf_r;

  logic        [LW-1:0]              left, right;
  logic        [CW-1:0]              i_dec, i_inc;
  logic signed [hse_pkg::DATA_W-1:0] cand_r_val;
  logic        [AW-1:0]              cand_r_idx;
  logic                              room;

  logic                              we;
  logic        [AW-1:0]              wa;
  logic signed [hse_pkg::DATA_W-1:0] wd;
  logic        [AW-1:0]              rd_addr;

  assign left  = {1'b0, node_r, 1'b1};
  assign right = left + LW'(1);
  assign i_dec = i_r - CW'(1);
  assign i_inc = i_r + CW'(1);
  assign room  = (count_r < CW'(MAX_ITEMS));

  // larger of the two children once both are read
  always_comb begin
    if (rd_data_r > big_val_r) begin
      cand_r_val = rd_data_r;
      cand_r_idx = right[AW-1:0];
    end else begin
      cand_r_val = big_val_r;
      cand_r_idx = big_idx_r;
    end
  end

  always_comb begin
    status.left_in   = (left <= LW'(end_r));
    status.right_in  = (right <= LW'(end_r));
    status.descend_l = (hold_r < rd_data_r);
    status.descend_r = (hold_r < cand_r_val);
    status.i_zero    = (i_r == '0);
    status.n_lt2     = (count_r < CW'(2));
    status.emit_last = (i_inc == count_r);
  end

  // memory port selection
  always_comb begin
    we      = 1'b0;
    wa      = node_r;
    wd      = hold_r;
    rd_addr = left[AW-1:0];
    unique case (cmd.op)
      hse_pkg::DP_LOAD: begin
        we = room;
        wa = count_r[AW-1:0];
        wd = in_value;
      end
      hse_pkg::DP_BUILD_RD: rd_addr = i_dec[AW-1:0];
      hse_pkg::DP_SIFT_CHK: we = !status.left_in;
      hse_pkg::DP_SIFT_L: begin
        rd_addr = right[AW-1:0];
        if (!status.right_in) begin
          we = 1'b1;
          wd = status.descend_l ? rd_data_r : hold_r;
        end
      end
      hse_pkg::DP_SIFT_R: begin
        we = 1'b1;
        wd = status.descend_r ? cand_r_val : hold_r;
      end
      hse_pkg::DP_EXT_RD0:  rd_addr = '0;
      hse_pkg::DP_EXT_RDI:  rd_addr = i_r[AW-1:0];
      hse_pkg::DP_EXT_SWAP: begin
        we = 1'b1;
        wa = i_r[AW-1:0];
        wd = big_val_r;
      end
      hse_pkg::DP_EMIT_INIT: rd_addr = '0;
      hse_pkg::DP_EMIT:      rd_addr = i_inc[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.op == hse_pkg::DP_LOAD) begin
        if (room) count_r <= count_r + CW'(1);
        else      ovf_r   <= 1'b1;
      end else if (cmd.op == hse_pkg::DP_EMIT && status.emit_last) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hse_pkg::DP_SETUP: begin
        i_r   <= count_r >> 1;
        end_r <= AW'(count_r - CW'(1));
      end
      hse_pkg::DP_BUILD_RD: begin
        node_r <= i_dec[AW-1:0];
        i_r    <= i_dec;
      end
      hse_pkg::DP_HOLD: hold_r <= rd_data_r;
      hse_pkg::DP_SIFT_L: begin
        if (status.right_in) begin
          big_val_r <= rd_data_r;
          big_idx_r <= left[AW-1:0];
        end else if (status.descend_l) begin
          node_r <= left[AW-1:0];
        end
      end
      hse_pkg::DP_SIFT_R: begin
        if (status.descend_r) node_r <= cand_r_idx;
      end
      hse_pkg::DP_EXT_INIT: i_r <= count_r - CW'(1);
      hse_pkg::DP_EXT_RDI:  big_val_r <= rd_data_r;
      hse_pkg::DP_EXT_SWAP: begin
        hold_r <= rd_data_r;
        node_r <= '0;
        end_r  <= i_dec[AW-1:0];
        i_r    <= i_dec;
      end
      hse_pkg::DP_EMIT_INIT: i_r <= '0;
      hse_pkg::DP_EMIT:      i_r <= i_inc;
      default: ;
    endcase
  end

  assign out_sorted_value = rd_data_r;
  assign out_final_res    = status.emit_last;
  assign out_dropped      = ovf_r;

endmodule

// ===== hdl/heap_sort_engine.sv =====
// a word without last is stored when taken and the engine is free the next cycle
// a last word starts the sort: heap build then extraction; each sift visits a heap level
// through SIFT_CHK, SIFT_L and, with a right child, SIFT_R, one read at a time on the single store read port
// results then leave as a burst of n words, one per cycle, which the receiver cannot stall
// reset clears the controller, the fill count and the dropped flag; the store is not cleared
// ----------------------------------------------------------------------------
// heap_sort_engine
// collects signed words and returns them in ascending order via an in-place heap sort
// ----------------------------------------------------------------------------
module heap_sort_engine #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel: word taken when start is high and busy is low
  input  logic                              start,
  output logic                              busy,
  input  logic signed [hse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  // result channel: one word per strobe cycle
  output logic                              out_strobe,
  output logic signed [hse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_final_res,
  output logic                              out_dropped
);

  // command and status between sequencer and datapath
  hse_pkg::hse_cmd_t    cmd;
  hse_pkg::hse_status_t status;

  // sequencer: loads words, runs the build and extraction loops, drives the burst
  hse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_last    (in_last),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath: element store with one write and one registered read port,
  // sift-down moves a hole towards the leaves and drops the held word in at the end
  hse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .status           (status),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_dropped      (out_dropped)
  );

endmodule

// ===== tb/sv/tb_heap_sort_engine.sv =====
// ----------------------------------------------------------------------------
// tb_heap_sort_engine
// self-checking bench for the heap sort engine: words are loaded one at a
// time, a word marked last starts the sort, and every returned word is checked
// against an in-bench heap sort of the same list, including the dropped flag
// ----------------------------------------------------------------------------
module tb_heap_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W       = hse_pkg::DATA_W;
  localparam int CAPACITY     = hse_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_WORDS = 96;
  // the engine is free in the cycle after a word without last, so a short tail suffices
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // shape of the value stream within one run
  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_DESCENDING
  } fill_mode_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     is_final;
    logic                     dropped;
  } sorted_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_res;
  logic                     out_dropped;

  // predictor copy of the engine state
  logic signed [DATA_W-1:0] held_vals [CAPACITY];
  logic signed [DATA_W-1:0] heap_buf  [CAPACITY];
  int                       held_count    = 0;
  bit                       held_overflow = 1'b0;

  // words still owed by the engine, oldest first
  sorted_word_t sorted_queue [$];
  sorted_word_t owed_word;

  int  error_count     = 0;
  int  words_sent      = 0;
  int  runs_done       = 0;
  int  dropped_runs    = 0;
  int  results_checked = 0;
  bit  no_idle         = 1'b0;

  heap_sort_engine #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_strobe      (out_strobe),
    .out_sorted_value(out_sorted_value),
    .out_final_res   (out_final_res),
    .out_dropped     (out_dropped)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // push the entry at node down within heap_buf[0..last_idx]
  function automatic void heap_sift(int node, int last_idx);
    int                       left;
    int                       right;
    int                       big;
    bit                       done;
    logic signed [DATA_W-1:0] tmp;
    done = 1'b0;
    while (!done) begin
      left  = 2 * node + 1;
      right = left + 1;
      if (left > last_idx) begin
        done = 1'b1;
      end else begin
        big = left;
        if (right <= last_idx && heap_buf[right] > heap_buf[left]) begin
          big = right;
        end
        if (heap_buf[node] < heap_buf[big]) begin
          tmp            = heap_buf[big];
          heap_buf[big]  = heap_buf[node];
          heap_buf[node] = tmp;
          node           = big;
        end else begin
          done = 1'b1;
        end
      end
    end
  endfunction

  // account for one accepted word; a last word queues the whole sorted run
  function automatic void predict_word(logic signed [DATA_W-1:0] v, logic l);
    int                       n;
    logic signed [DATA_W-1:0] tmp;
    sorted_word_t             w;
    if (held_count < CAPACITY) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      // store full: the word is lost, the run is flagged
      held_overflow = 1'b1;
    end
    if (l) begin
      n = held_count;
      for (int i = 0; i < n; i++) heap_buf[i] = held_vals[i];
      if (n >= 2) begin
        // heap build from the last parent, then repeated root extraction
        for (int i = n / 2; i > 0; i--) heap_sift(i - 1, n - 1);
        for (int i = n - 1; i > 0; i--) begin
          tmp         = heap_buf[0];
          heap_buf[0] = heap_buf[i];
          heap_buf[i] = tmp;
          heap_sift(0, i - 1);
        end
      end
      for (int k = 0; k < n; k++) begin
        w.value    = heap_buf[k];
        w.is_final = (k + 1 == n);
        w.dropped  = held_overflow;
        sorted_queue.push_back(w);
      end
      runs_done++;
      if (held_overflow) dropped_runs++;
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every strobe cycle must match the oldest owed word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (sorted_queue.size() == 0) begin
        $error("unexpected result word: sorted_value %0d", out_sorted_value);
        error_count++;
      end else begin
        owed_word = sorted_queue.pop_front();
        results_checked++;
        if (out_sorted_value !== owed_word.value) begin
          $error("sorted_value mismatch: expected %0d, actual %0d",
                 owed_word.value, out_sorted_value);
          error_count++;
        end
        if (out_final_res !== owed_word.is_final) begin
          $error("final_res mismatch: expected %0b, actual %0b",
                 owed_word.is_final, out_final_res);
          error_count++;
        end
        if (out_dropped !== owed_word.dropped) begin
          $error("dropped mismatch: expected %0b, actual %0b",
                 owed_word.dropped, out_dropped);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // drive one word and hold it until the engine takes it
  task automatic send_word(input logic signed [DATA_W-1:0] v, input logic l);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(v, l);
    words_sent++;
  endtask

  // sender idle cycles; the data lines carry junk meanwhile
  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(0, 1));
    end
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle)  return 0;
    if (r < 55)   return 0;
    if (r < 85)   return $urandom_range(1, 3);
    if (r < 97)   return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // hold the sender off until every owed word has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sorted_queue.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(fill_mode_t mode, int k,
                                                          logic signed [DATA_W-1:0] seed);
    unique case (mode)
      FILL_NARROW: begin
        // tiny range forces many equal values
        return $signed($urandom_range(0, 7)) - 4;
      end
      FILL_EXTREME: begin
        unique case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      FILL_DESCENDING: begin
        return seed - k * 3;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // one run of len words, the last one marked, with gaps between words
  task automatic send_run(input int len, input fill_mode_t mode);
    logic signed [DATA_W-1:0] seed;
    seed = $urandom;
    for (int k = 0; k < len; k++) begin
      idle_gap(pick_gap());
      send_word(pick_value(mode, k, seed), k == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // one-word runs at both ends of the value range and at zero
  task automatic test_single_word_runs();
    send_word(VAL_MIN, 1'b1);
    send_word(VAL_MAX, 1'b1);
    send_word('0, 1'b1);
  endtask

  // extremes and alternating bit patterns in one list
  task automatic test_extreme_mix();
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(VAL_MIN + 1, 1'b1);
  endtask

  // repeated values; words without last must stay silent
  task automatic test_equal_values();
    send_word(7, 1'b0);
    send_word(7, 1'b0);
    send_word(-3, 1'b0);
    wait_drained();
    idle_gap(5);
    send_word(7, 1'b0);
    send_word(-3, 1'b0);
    send_word(7, 1'b1);
  endtask

  // two-word runs in both orders
  task automatic test_two_word_runs();
    send_word(1, 1'b0);
    send_word(-1, 1'b1);
    send_word(-1, 1'b0);
    send_word(1, 1'b1);
  endtask

  // exact capacity, a last word that lands on a full store, and extra words
  task automatic test_full_store();
    send_run(CAPACITY, FILL_RANDOM);
    wait_drained();
    send_run(CAPACITY + 1, FILL_RANDOM);
    send_run(CAPACITY + 6, FILL_NARROW);
    // a short clean run right after an overflowed one must not carry the flag
    send_run(3, FILL_RANDOM);
  endtask

  // random runs, mostly short, some long, a few past capacity
  task automatic test_random_runs();
    int         start_count;
    int         len;
    int         r;
    int         run_idx;
    fill_mode_t mode;
    start_count = words_sent;
    run_idx     = 0;
    while (words_sent - start_count < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 10);
      else if (r < 88) len = $urandom_range(11, 32);
      else if (r < 95) len = $urandom_range(33, CAPACITY);
      else             len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      mode    = fill_mode_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 3) == 0);
      send_run(len, mode);
      run_idx++;
      if (run_idx % 7 == 0) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    in_last  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_single_word_runs();
    test_extreme_mix();
    test_equal_values();
    test_two_word_runs();
    test_full_store();
    test_random_runs();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sorted %0d runs from %0d words, %0d of them with dropped words",
             runs_done, words_sent, dropped_runs);
    $display("checked %0d result words", results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
